// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off by arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge
`define IMUGB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define IMUGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IMUGB_ASSERT_ALWAYS(lbl, prop, msg)
`define IMUGB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/imugb_pkg.sv
// ----------------------------------------------------------------------------
// imugb_pkg
// shared types and constants of the imu gyro bias calibration unit
// ----------------------------------------------------------------------------
`default_nettype none

package imugb_pkg;

	// calibration length as a power of two, so the bias is a shift
	localparam int STILL_SAMPLES_LOG2 = 10;
	localparam int STILL_SAMPLES      = 1 << STILL_SAMPLES_LOG2;
	localparam int CNT_W              = STILL_SAMPLES_LOG2 + 1;
	localparam int SUM_W              = 16 + CNT_W;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// register index codes
	localparam logic [1:0] REG_ACC_BIAS_X = 2'd0;
	localparam logic [1:0] REG_ACC_BIAS_Y = 2'd1;
	localparam logic [1:0] REG_ACC_BIAS_Z = 2'd2;
	localparam logic [1:0] REG_STILL_THR  = 2'd3;

	typedef logic [1:0] status_t;

	localparam status_t ST_STILL   = 2'd0;
	localparam status_t ST_RESTART = 2'd1;
	localparam status_t ST_DONE    = 2'd2;
	localparam status_t ST_RUN     = 2'd3;

	typedef struct packed {
		logic signed [15:0] acc_bias_x;
		logic signed [15:0] acc_bias_y;
		logic signed [15:0] acc_bias_z;
		logic [31:0]        thr2;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] rate_bias_x;
		logic signed [15:0] rate_bias_y;
		logic signed [15:0] rate_bias_z;
	} cal_t;

endpackage

`default_nettype wire

// File: rtl/imugb_cfg.sv
// ----------------------------------------------------------------------------
// imugb_cfg
// apb register file: accelerometer offsets and the still threshold
// ----------------------------------------------------------------------------
`default_nettype none

module imugb_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [imugb_pkg::APB_AW-1:0]  paddr,
	input  wire logic [imugb_pkg::APB_DW-1:0]  pwdata,
	output logic      [imugb_pkg::APB_DW-1:0]  prdata,
	output logic                               pready,
	output imugb_pkg::cfg_t                    cfg
);
	import imugb_pkg::*;

	logic signed [15:0] acc_bias_x_q;
	logic signed [15:0] acc_bias_y_q;
	logic signed [15:0] acc_bias_z_q;
	logic [15:0]        thr_q;
	logic [31:0]        thr2_q;
	logic [1:0]         idx;
	logic               wr;
	logic [31:0]        wr_thr2;

	assign pready  = 1'b1;
	assign idx     = paddr[3:2];
	assign wr      = psel & penable & pwrite & pready;
	// squared threshold kept alongside so the magnitude test needs no threshold multiplier
	assign wr_thr2 = {16'b0, pwdata[15:0]} * {16'b0, pwdata[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_bias_x_q <= '0;
			acc_bias_y_q <= '0;
			acc_bias_z_q <= '0;
			thr_q        <= 16'hFFFF;
			thr2_q       <= 32'hFFFE_0001;
		end else if (wr) begin
			case (idx)
				REG_ACC_BIAS_X: acc_bias_x_q <= pwdata[15:0];
				REG_ACC_BIAS_Y: acc_bias_y_q <= pwdata[15:0];
				REG_ACC_BIAS_Z: acc_bias_z_q <= pwdata[15:0];
				REG_STILL_THR: begin
					thr_q  <= pwdata[15:0];
					thr2_q <= wr_thr2;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ACC_BIAS_X: prdata = APB_DW'(acc_bias_x_q);
			REG_ACC_BIAS_Y: prdata = APB_DW'(acc_bias_y_q);
			REG_ACC_BIAS_Z: prdata = APB_DW'(acc_bias_z_q);
			REG_STILL_THR:  prdata = {16'b0, thr_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.acc_bias_x = acc_bias_x_q;
	assign cfg.acc_bias_y = acc_bias_y_q;
	assign cfg.acc_bias_z = acc_bias_z_q;
	assign cfg.thr2       = thr2_q;

endmodule

`default_nettype wire

// File: rtl/imugb_cal.sv
// ----------------------------------------------------------------------------
// imugb_cal
// calibration state: still sums and count, learned gyro bias, phase flag
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imugb_cal (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic [31:0]        mag2,
	input  wire logic [31:0]        thr2,
	output imugb_pkg::cal_t         cal
);
	import imugb_pkg::*;

	localparam logic [SUM_W-1:0] RND = SUM_W'(STILL_SAMPLES - 1);

	logic                    calibrated_q;
	logic [CNT_W-1:0]        still_count_q;
	logic signed [SUM_W-1:0] rate_sum_q [3];
	logic signed [15:0]      rate_bias_q [3];
	logic signed [15:0]      g [3];
	logic signed [15:0]      bias_new [3];
	logic signed [SUM_W-1:0] adj [3];
	logic signed [SUM_W-1:0] quo [3];
	logic                    full;
	logic                    moving;
	status_t                 status;

	assign g[0]   = gyro_x;
	assign g[1]   = gyro_y;
	assign g[2]   = gyro_z;
	assign full   = (still_count_q == CNT_W'(STILL_SAMPLES));
	assign moving = (mag2 > thr2);

	// divide toward zero: bias a negative sum up before the arithmetic shift
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			adj[i]      = rate_sum_q[i] + (rate_sum_q[i][SUM_W-1] ? RND : '0);
			quo[i]      = adj[i] >>> STILL_SAMPLES_LOG2;
			bias_new[i] = quo[i][15:0];
		end
	end

	always_comb begin
		if (calibrated_q)
			status = ST_RUN;
		else if (full)
			status = ST_DONE;
		else if (moving)
			status = ST_RESTART;
		else
			status = ST_STILL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q  <= 1'b0;
			still_count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				rate_sum_q[i]  <= '0;
				rate_bias_q[i] <= '0;
			end
		end else if (fire) begin
			case (status)
				ST_DONE: begin
					calibrated_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						rate_bias_q[i] <= bias_new[i];
				end
				ST_RESTART: begin
					still_count_q <= '0;
					for (int i = 0; i < 3; i++)
						rate_sum_q[i] <= '0;
				end
				ST_STILL: begin
					still_count_q <= still_count_q + 1'b1;
					for (int i = 0; i < 3; i++)
						rate_sum_q[i] <= rate_sum_q[i] + SUM_W'(g[i]);
				end
				default: ;
			endcase
		end
	end

	assign cal.status      = status;
	assign cal.rate_bias_x = rate_bias_q[0];
	assign cal.rate_bias_y = rate_bias_q[1];
	assign cal.rate_bias_z = rate_bias_q[2];

	`IMUGB_ASSERT_NEXT(a_cal_sticky, calibrated_q, calibrated_q, "run phase left before reset")
	`IMUGB_ASSERT_ALWAYS(a_cnt_max, still_count_q <= CNT_W'(STILL_SAMPLES), "still count overran")
	`IMUGB_ASSERT_NEXT(a_restart_clr, fire && (status == ST_RESTART), still_count_q == '0, "restart left count")
	`IMUGB_ASSERT_NEXT(a_done_run, fire && (status == ST_DONE), calibrated_q && (still_count_q == CNT_W'(STILL_SAMPLES)), "finish beat did not enter run phase")

endmodule

`default_nettype wire

// File: rtl/imu_gyro_bias_calibrate_correct_unit.sv
// ----------------------------------------------------------------------------
// imu_gyro_bias_calibrate_correct_unit
// stationary gyro bias calibration and north-west-up sample correction
// ----------------------------------------------------------------------------
// One beat in, one beat out, one item per clock when the output side keeps up.
// A result passes the input register, the gyro square register and the result
// register in that order, and a stall can hold it in any of them. After reset
// the unit calibrates: it needs 1024 consecutive still samples (gyro magnitude
// at or below still_threshold) plus one more beat that latches the bias, and
// only then reports corrected data (status 3). The user is to write biases and
// the threshold over the apb port only while no beat is in flight; the block
// itself does not enforce this.
`default_nettype none

module imu_gyro_bias_calibrate_correct_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [imugb_pkg::APB_AW-1:0]  paddr,
	input  wire logic [imugb_pkg::APB_DW-1:0]  pwdata,
	output logic      [imugb_pkg::APB_DW-1:0]  prdata,
	output logic                               pready,
	// input samples
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [15:0]            acc_x,
	input  wire logic signed [15:0]            acc_y,
	input  wire logic signed [15:0]            acc_z,
	input  wire logic signed [15:0]            gyro_x,
	input  wire logic signed [15:0]            gyro_y,
	input  wire logic signed [15:0]            gyro_z,
	// results
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output imugb_pkg::status_t                 status,
	output logic signed [16:0]                 out_acc_north,
	output logic signed [16:0]                 out_acc_west,
	output logic signed [16:0]                 out_acc_up,
	output logic signed [16:0]                 out_rate_north,
	output logic signed [16:0]                 out_rate_west,
	output logic signed [16:0]                 out_rate_up
);
	import imugb_pkg::*;

	cfg_t cfg;
	cal_t cal;

	logic               s1_valid_q;
	logic signed [15:0] ax_s1, ay_s1, az_s1, gx_s1, gy_s1, gz_s1;
	logic               s2_valid_q;
	logic signed [15:0] ax_s2, ay_s2, az_s2, gx_s2, gy_s2, gz_s2;
	logic [30:0]        sqx_s2, sqy_s2, sqz_s2;
	logic               out_valid_q;
	status_t            status_q;
	logic signed [16:0] acc_n_q, acc_w_q, acc_u_q, rate_n_q, rate_w_q, rate_u_q;

	logic               s1_go, s2_go, fire;
	logic signed [31:0] px, py, pz;
	logic [31:0]        mag2;
	logic               run;

	imugb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stall handling: each stage moves when the one after it has room
	assign s2_go    = !out_valid_q || out_ready;
	assign s1_go    = !s2_valid_q || s2_go;
	assign in_ready = !s1_valid_q || s1_go;
	assign fire     = s2_valid_q && s2_go;

	assign px = gx_s1 * gx_s1;
	assign py = gy_s1 * gy_s1;
	assign pz = gz_s1 * gz_s1;

	assign mag2 = {1'b0, sqx_s2} + {1'b0, sqy_s2} + {1'b0, sqz_s2};

	imugb_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.gyro_x (gx_s2),
		.gyro_y (gy_s2),
		.gyro_z (gz_s2),
		.mag2   (mag2),
		.thr2   (cfg.thr2),
		.cal    (cal)
	);

	assign run = (cal.status == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				s1_valid_q <= in_valid;
			if (s1_go)
				s2_valid_q <= s1_valid_q;
			if (s2_go)
				out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ax_s1 <= acc_x;
			ay_s1 <= acc_y;
			az_s1 <= acc_z;
			gx_s1 <= gyro_x;
			gy_s1 <= gyro_y;
			gz_s1 <= gyro_z;
		end
		if (s1_go && s1_valid_q) begin
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			gx_s2  <= gx_s1;
			gy_s2  <= gy_s1;
			gz_s2  <= gz_s1;
			sqx_s2 <= px[30:0];
			sqy_s2 <= py[30:0];
			sqz_s2 <= pz[30:0];
		end
		if (fire) begin
			status_q <= cal.status;
			// remap to north-west-up: (y, -x, z); data is zero while calibrating
			acc_n_q  <= run ? 17'(ay_s2) - 17'(cfg.acc_bias_y) : '0;
			acc_w_q  <= run ? 17'(cfg.acc_bias_x) - 17'(ax_s2) : '0;
			acc_u_q  <= run ? 17'(az_s2) - 17'(cfg.acc_bias_z) : '0;
			rate_n_q <= run ? 17'(gy_s2) - 17'(cal.rate_bias_y) : '0;
			rate_w_q <= run ? 17'(cal.rate_bias_x) - 17'(gx_s2) : '0;
			rate_u_q <= run ? 17'(gz_s2) - 17'(cal.rate_bias_z) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_acc_north  = acc_n_q;
	assign out_acc_west   = acc_w_q;
	assign out_acc_up     = acc_u_q;
	assign out_rate_north = rate_n_q;
	assign out_rate_west  = rate_w_q;
	assign out_rate_up    = rate_u_q;

endmodule

`default_nettype wire

// File: tb/tb_imu_gyro_bias_calibrate_correct_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_gyro_bias_calibrate_correct_unit
// Feeds imu sample beats through the calibration and correction unit with
// random stalls on both sides, and checks every result beat against a
// bit-exact model of the still-sample averaging and the north-west-up remap.
// Register settings change only while the unit is drained.
// ----------------------------------------------------------------------------

module tb_imu_gyro_bias_calibrate_correct_unit;
	import imugb_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 12;
	localparam int PIPE_SETTLE  = 8;
	localparam int LONG_HOLD    = 80;
	localparam int STALL_LIMIT  = 2000;
	localparam int CAL_SAMPLES  = STILL_SAMPLES;

	typedef struct packed {
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
	} imu_sample_t;

	typedef struct packed {
		status_t            status;
		logic signed [16:0] acc_north;
		logic signed [16:0] acc_west;
		logic signed [16:0] acc_up;
		logic signed [16:0] rate_north;
		logic signed [16:0] rate_west;
		logic signed [16:0] rate_up;
	} imu_result_t;

	class imu_cal_scoreboard;
		int acc_bias[3];
		int still_thr;
		bit calibrated;
		int still_count;
		int rate_sum[3];
		int rate_bias[3];
		imu_result_t pending_results[$];
		int errors;
		int beats_in;
		int beats_out;
		int status_hist[4];

		function new();
			for (int i = 0; i < 3; i++) begin
				acc_bias[i]  = 0;
				rate_sum[i]  = 0;
				rate_bias[i] = 0;
			end
			for (int i = 0; i < 4; i++)
				status_hist[i] = 0;
			still_thr   = 65535;
			calibrated  = 1'b0;
			still_count = 0;
			errors      = 0;
			beats_in    = 0;
			beats_out   = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_ACC_BIAS_X: acc_bias[0] = $signed(val);
				REG_ACC_BIAS_Y: acc_bias[1] = $signed(val);
				REG_ACC_BIAS_Z: acc_bias[2] = $signed(val);
				REG_STILL_THR:  still_thr   = val;
				default: ;
			endcase
		endfunction

		function void accept_sample(imu_sample_t s);
			imu_result_t r;
			int a[3];
			int g[3];
			longint mag2;
			longint thr2;
			a[0] = s.acc_x;
			a[1] = s.acc_y;
			a[2] = s.acc_z;
			g[0] = s.gyro_x;
			g[1] = s.gyro_y;
			g[2] = s.gyro_z;
			r = '0;
			beats_in++;
			if (calibrated) begin
				r.status     = ST_RUN;
				r.acc_north  = 17'(a[1] - acc_bias[1]);
				r.acc_west   = 17'(acc_bias[0] - a[0]);
				r.acc_up     = 17'(a[2] - acc_bias[2]);
				r.rate_north = 17'(g[1] - rate_bias[1]);
				r.rate_west  = 17'(rate_bias[0] - g[0]);
				r.rate_up    = 17'(g[2] - rate_bias[2]);
			end else if (still_count >= CAL_SAMPLES) begin
				// signed int division truncates toward zero
				for (int i = 0; i < 3; i++)
					rate_bias[i] = rate_sum[i] / CAL_SAMPLES;
				calibrated = 1'b1;
				r.status   = ST_DONE;
			end else begin
				mag2 = 0;
				for (int i = 0; i < 3; i++)
					mag2 += longint'(g[i]) * g[i];
				thr2 = longint'(still_thr) * still_thr;
				if (mag2 > thr2) begin
					for (int i = 0; i < 3; i++)
						rate_sum[i] = 0;
					still_count = 0;
					r.status    = ST_RESTART;
				end else begin
					for (int i = 0; i < 3; i++)
						rate_sum[i] += g[i];
					still_count++;
					r.status = ST_STILL;
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
			if (a !== e) begin
				$error("%s: expected %0d, actual %0d", name, e, a);
				errors++;
			end
		endfunction

		function void compare_output(imu_result_t act);
			imu_result_t exp_r;
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected, status %0d", act.status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			status_hist[exp_r.status]++;
			check_field("status", exp_r.status, act.status);
			check_field("out_acc_north", exp_r.acc_north, act.acc_north);
			check_field("out_acc_west", exp_r.acc_west, act.acc_west);
			check_field("out_acc_up", exp_r.acc_up, act.acc_up);
			check_field("out_rate_north", exp_r.rate_north, act.rate_north);
			check_field("out_rate_west", exp_r.rate_west, act.rate_west);
			check_field("out_rate_up", exp_r.rate_up, act.rate_up);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [15:0]       acc_x;
	logic signed [15:0]       acc_y;
	logic signed [15:0]       acc_z;
	logic signed [15:0]       gyro_x;
	logic signed [15:0]       gyro_y;
	logic signed [15:0]       gyro_z;
	logic                     out_valid;
	logic                     out_ready;
	status_t                  status;
	logic signed [16:0]       out_acc_north;
	logic signed [16:0]       out_acc_west;
	logic signed [16:0]       out_acc_up;
	logic signed [16:0]       out_rate_north;
	logic signed [16:0]       out_rate_west;
	logic signed [16:0]       out_rate_up;

	imu_cal_scoreboard sb;
	bit tx_gaps;
	bit rx_gaps;
	bit long_hold;
	int gyro_center[3];
	int spread;
	int stall_cycles;

	imu_gyro_bias_calibrate_correct_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.acc_x          (acc_x),
		.acc_y          (acc_y),
		.acc_z          (acc_z),
		.gyro_x         (gyro_x),
		.gyro_y         (gyro_y),
		.gyro_z         (gyro_z),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_acc_north  (out_acc_north),
		.out_acc_west   (out_acc_west),
		.out_acc_up     (out_acc_up),
		.out_rate_north (out_rate_north),
		.out_rate_west  (out_rate_west),
		.out_rate_up    (out_rate_up)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int rnd16();
		logic signed [15:0] v;
		v = 16'($urandom);
		return v;
	endfunction

	function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy, int gz);
		imu_sample_t s;
		s.acc_x  = 16'(ax);
		s.acc_y  = 16'(ay);
		s.acc_z  = 16'(az);
		s.gyro_x = 16'(gx);
		s.gyro_y = 16'(gy);
		s.gyro_z = 16'(gz);
		return s;
	endfunction

	function automatic imu_sample_t rand_sample();
		return mk(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
	endfunction

	// per-axis bound of thr/2 keeps the squared magnitude under thr^2
	function automatic void pick_center(int thr);
		spread = thr / 4;
		for (int i = 0; i < 3; i++)
			gyro_center[i] = int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic imu_sample_t cal_sample(int thr, bit moving);
		int g[3];
		int k;
		int mag;
		for (int i = 0; i < 3; i++)
			g[i] = gyro_center[i] + int'($urandom_range(0, 2 * spread)) - spread;
		if (moving) begin
			k      = $urandom_range(0, 2);
			mag    = $urandom_range(thr + 1, 32767);
			g[k]   = $urandom_range(0, 1) ? mag : -mag;
		end
		return mk(rnd16(), rnd16(), rnd16(), g[0], g[1], g[2]);
	endfunction

	task automatic send_sample(imu_sample_t s);
		@(negedge clk);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		acc_x    <= s.acc_x;
		acc_y    <= s.acc_y;
		acc_z    <= s.acc_z;
		gyro_x   <= s.gyro_x;
		gyro_y   <= s.gyro_y;
		gyro_z   <= s.gyro_z;
		do @(posedge clk); while (!in_ready);
		sb.accept_sample(s);
	endtask

	// stop offering beats and let every result come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= (idx == REG_STILL_THR) ? {16'h0000, val} : {{16{val[15]}}, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(int bx, int by, int bz, int thr);
		drain();
		apb_write(REG_ACC_BIAS_X, 16'(bx));
		apb_write(REG_ACC_BIAS_Y, 16'(by));
		apb_write(REG_ACC_BIAS_Z, 16'(bz));
		apb_write(REG_STILL_THR, 16'(thr));
	endtask

	initial begin : output_side
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		imu_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.status     = status;
			seen.acc_north  = out_acc_north;
			seen.acc_west   = out_acc_west;
			seen.acc_up     = out_acc_up;
			seen.rate_north = out_rate_north;
			seen.rate_west  = out_rate_west;
			seen.rate_up    = out_rate_up;
			sb.compare_output(seen);
		end
	end

	always @(posedge clk) begin : stall_watchdog
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int thr;
		sb           = new();
		stall_cycles = 0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		acc_x        = '0;
		acc_y        = '0;
		acc_z        = '0;
		gyro_x       = '0;
		gyro_y       = '0;
		gyro_z       = '0;
		tx_gaps      = 1'b1;
		rx_gaps      = 1'b1;
		long_hold    = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// magnitude right at the threshold stays still, one count over restarts
		set_config(rnd16(), rnd16(), rnd16(), 1000);
		send_sample(mk(rnd16(), rnd16(), rnd16(), 0, 0, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 1000, 0, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 600, -800, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 0, 0, -1001));
		send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
		send_sample(mk(32767, 32767, 32767, 0, 1000, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 577, 577, 577));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 578, 578, 578));

		// zero threshold: only an all-zero gyro counts as still
		set_config(rnd16(), rnd16(), rnd16(), 0);
		send_sample(mk(rnd16(), rnd16(), rnd16(), 0, 0, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 0, 0, 1));
		send_sample(mk(rnd16(), rnd16(), rnd16(), -1, 0, 0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 0, 0, 0));

		// full threshold: even full-scale gyro is still
		set_config(rnd16(), rnd16(), rnd16(), 65535);
		send_sample(mk(rnd16(), rnd16(), rnd16(), -32768, -32768, -32768));
		send_sample(mk(rnd16(), rnd16(), rnd16(), 32767, 32767, 32767));
		send_sample(mk(rnd16(), rnd16(), rnd16(), -32768, 32767, -32768));

		// still runs broken by motion and noise
		for (int p = 0; p < 3; p++) begin
			thr     = $urandom_range(500, 30000);
			tx_gaps = $urandom_range(0, 1);
			set_config(rnd16(), rnd16(), rnd16(), thr);
			pick_center(thr);
			repeat (4) begin
				repeat ($urandom_range(1, 40)) send_sample(cal_sample(thr, 1'b0));
				repeat ($urandom_range(1, 3))
					send_sample($urandom_range(0, 1) ? cal_sample(thr, 1'b1) : rand_sample());
			end
		end

		// one full still run, then the beat that latches the bias
		tx_gaps = 1'b1;
		thr     = $urandom_range(20000, 30000);
		set_config(rnd16(), rnd16(), rnd16(), thr);
		pick_center(thr);
		send_sample(cal_sample(thr, 1'b1));
		repeat (CAL_SAMPLES) send_sample(cal_sample(thr, 1'b0));
		send_sample(mk(rnd16(), rnd16(), rnd16(), -32768, -32768, -32768));

		// corrected data at the ends of the 17-bit range
		set_config(32767, 32767, 32767, 0);
		send_sample(mk(-32768, -32768, -32768, -32768, 32767, -32768));
		send_sample(mk(32767, 32767, 32767, 32767, -32768, 32767));
		send_sample(mk(0, 0, 0, 0, 0, 0));
		set_config(-32768, -32768, -32768, 65535);
		send_sample(mk(-32768, -32768, -32768, -32768, 32767, -32768));
		send_sample(mk(32767, 32767, 32767, 32767, -32768, 32767));
		send_sample(mk(0, 0, 0, 0, 0, 0));

		set_config(rnd16(), rnd16(), rnd16(), $urandom_range(0, 65535));
		repeat (100) send_sample(rand_sample());
		// output stalled for a long stretch while beats keep coming
		tx_gaps   = 1'b0;
		long_hold = 1'b1;
		repeat (40) send_sample(rand_sample());
		tx_gaps = 1'b1;
		repeat (60) send_sample(rand_sample());
		// input held until the pipe is empty
		drain();
		repeat (100) send_sample(rand_sample());

		set_config(rnd16(), rnd16(), rnd16(), $urandom_range(0, 65535));
		repeat (100) send_sample(rand_sample());

		// back-to-back beats, no stalls on either side
		set_config(rnd16(), rnd16(), rnd16(), $urandom_range(0, 65535));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (100) send_sample(rand_sample());

		drain();
		$display("calibration: %0d still, %0d restart, %0d finish beats; %0d corrected beats",
			sb.status_hist[ST_STILL], sb.status_hist[ST_RESTART],
			sb.status_hist[ST_DONE], sb.status_hist[ST_RUN]);
		$display("%0d beats in, %0d beats out, %0d mismatches",
			sb.beats_in, sb.beats_out, sb.errors);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
